// File: hdl/skt_pkg.sv
// Shared types, codes and constants for the sorted key table.
package skt_pkg;

   localparam int SKT_DEPTH = 128;

   localparam int KEY_IN_W   = 32;
   localparam int KEY_W      = 31;
   localparam int SCORE_IN_W = 11;
   localparam int SCORE_W    = 10;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 4;
   localparam int POS_W      = 10;
   localparam int GRADE_W    = 2;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 1;

   localparam logic [FUNC_W-1:0] FN_UPSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_UPDATED   = 4'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 4'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_BAD_SCORE = 4'd7;
   localparam logic [STATUS_W-1:0] ST_BOTH_BAD  = 4'd8;

   localparam logic [GRADE_W-1:0] GR_FAIL      = 2'd0;
   localparam logic [GRADE_W-1:0] GR_PASS      = 2'd1;
   localparam logic [GRADE_W-1:0] GR_EXCELLENT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PASS_THRESHOLD      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCELLENT_THRESHOLD = 1'd1;

   localparam logic [SCORE_W-1:0] SCORE_MAX           = 10'd1000;
   localparam logic [SCORE_W-1:0] PASS_THRESHOLD_RST  = 10'd600;
   localparam logic [SCORE_W-1:0] EXCEL_THRESHOLD_RST = 10'd850;

   // Broadcast to every cell when the held request completes.
   typedef struct packed {
      logic               insert;
      logic               delete;
      logic               update;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
   } skt_op_type;

endpackage

// File: hdl/skt_cell.sv
// One slot of the table: holds a key and score, compares, shifts with its neighbors.
module skt_cell import skt_pkg::*; #(
   parameter int DEPTH = SKT_DEPTH,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmp_en,
   input  logic signed [KEY_IN_W-1:0]   cmp_key,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   input  skt_op_type                   op,
   input  logic                         g_prev,
   input  logic [KEY_W-1:0]             left_key,
   input  logic [SCORE_W-1:0]           left_score,
   input  logic [KEY_W-1:0]             right_key,
   input  logic [SCORE_W-1:0]           right_score,
   output logic [KEY_W-1:0]             key_out,
   output logic [SCORE_W-1:0]           score_out,
   output logic                         eq_out,
   output logic                         g_out
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               eq_ff, gt_ff, g_ff;
   logic               occ, eq_now, gt_now;

   assign occ    = CNT_W'(INDEX) < count;
   assign eq_now = occ && ($signed({1'b0, key_ff}) == cmp_key);
   assign gt_now = $signed({1'b0, key_ff}) > cmp_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_ff <= 1'b0;
         gt_ff <= 1'b0;
         g_ff  <= 1'b0;
      end else if (cmp_en) begin
         eq_ff <= eq_now;
         gt_ff <= gt_now;
         g_ff  <= gt_now || !occ;
      end
   end

   always_comb begin
      key_in   = key_ff;
      score_in = score_ff;
      if (op.insert && g_ff) begin
         // first slot above the new key takes it; slots beyond move up
         if (g_prev) begin
            key_in   = left_key;
            score_in = left_score;
         end else begin
            key_in   = op.key;
            score_in = op.score;
         end
      end else if (op.delete && (eq_ff || gt_ff)) begin
         key_in   = right_key;
         score_in = right_score;
      end else if (op.update && eq_ff) begin
         score_in = op.score;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

   assign key_out   = key_ff;
   assign score_out = score_ff;
   assign eq_out    = eq_ff;
   assign g_out     = g_ff;

endmodule

// File: hdl/skt_pick.sv
// Encodes a one-hot slot select into its index and reads out that slot's score.
module skt_pick import skt_pkg::*; #(
   parameter int DEPTH = SKT_DEPTH
) (
   input  logic [DEPTH-1:0]              sel,
   input  logic [DEPTH-1:0][SCORE_W-1:0] scores,
   output logic [$clog2(DEPTH)-1:0]      index,
   output logic [SCORE_W-1:0]            score
);

   localparam int IDX_W = $clog2(DEPTH);

   always_comb begin
      index = '0;
      score = '0;
      for (int i = 0; i < DEPTH; i++) begin
         index = index | (sel[i] ? IDX_W'(i) : '0);
         score = score | (sel[i] ? scores[i] : '0);
      end
   end

endmodule

// File: hdl/sorted_key_table_unit.sv
// Sorted key/score table built as a chain of compare-and-shift cells.
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/req_stall | func, entry_key, entry_score
//   rsp_    | out       | rsp_valid/rsp_stall | status, position, key, score, grade, count
//   csr_    | in        | csr_valid/csr_ready | index, data (thresholds)
//
// Every cell compares its key in the accept cycle and registers the result; once the
// result register is free, the status is resolved and the cells shift or are rewritten in one step.
// One item is in work at a time; req_stall is high while it is held.
// The result register frees the table as soon as the word is loaded; a stalled
// result holds the next item after its compare. Synchronous reset empties the table
// (count to zero) and restores the thresholds to 600 and 850; no clearing pass.
module sorted_key_table_unit import skt_pkg::*; #(
   parameter int DEPTH = SKT_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [FUNC_W-1:0]            req_func,
   input  logic signed [KEY_IN_W-1:0]   req_entry_key,
   input  logic signed [SCORE_IN_W-1:0] req_entry_score,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [POS_W-1:0]             rsp_position,
   output logic [KEY_W-1:0]             rsp_result_key,
   output logic [SCORE_W-1:0]           rsp_result_score,
   output logic [GRADE_W-1:0]           rsp_grade,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [SCORE_W-1:0]           csr_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic                          busy_ff;
   logic [FUNC_W-1:0]             func_ff;
   logic signed [KEY_IN_W-1:0]    key_ff;
   logic signed [SCORE_IN_W-1:0]  score_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SCORE_W-1:0]            pass_thr_ff, excel_thr_ff;

   logic                          rsp_valid_ff;
   logic [STATUS_W-1:0]           status_ff;
   logic [POS_W-1:0]              pos_ff;
   logic [KEY_W-1:0]              rkey_ff;
   logic [SCORE_W-1:0]            rscore_ff;
   logic [GRADE_W-1:0]            grade_ff;
   logic [COUNT_W-1:0]            cnt_out_ff;

   logic                          accept, out_free, fire;
   logic                          hit, key_bad, score_bad, full, report;
   logic [STATUS_W-1:0]           status_in;
   logic [SCORE_W-1:0]            rscore_in;
   logic [GRADE_W-1:0]            grade_in;
   skt_op_type                    op;

   logic [DEPTH-1:0][KEY_W-1:0]   key_vec;
   logic [DEPTH-1:0][SCORE_W-1:0] score_vec;
   logic [DEPTH-1:0]              eq_vec, g_vec, ins_vec, sel_vec;
   logic [IDX_W-1:0]              pick_idx;
   logic [SCORE_W-1:0]            pick_score;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = busy_ff && out_free;
   assign csr_ready = 1'b1;

   // ---- cell chain ----
   assign op.insert = fire && (status_in == ST_INSERTED);
   assign op.delete = fire && (status_in == ST_DELETED);
   assign op.update = fire && (status_in == ST_UPDATED);
   assign op.key    = key_ff[KEY_W-1:0];
   assign op.score  = score_ff[SCORE_W-1:0];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic               g_prev;
         logic [KEY_W-1:0]   l_key, r_key;
         logic [SCORE_W-1:0] l_score, r_score;
         if (gi == 0) begin : g_first
            assign g_prev  = 1'b0;
            assign l_key   = '0;
            assign l_score = '0;
         end else begin : g_mid
            assign g_prev  = g_vec[gi-1];
            assign l_key   = key_vec[gi-1];
            assign l_score = score_vec[gi-1];
         end
         if (gi == DEPTH-1) begin : g_last
            assign r_key   = '0;
            assign r_score = '0;
         end else begin : g_inner
            assign r_key   = key_vec[gi+1];
            assign r_score = score_vec[gi+1];
         end
         skt_cell #(.DEPTH(DEPTH), .INDEX(gi)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmp_en      (accept),
            .cmp_key     (req_entry_key),
            .count       (count_ff),
            .op          (op),
            .g_prev      (g_prev),
            .left_key    (l_key),
            .left_score  (l_score),
            .right_key   (r_key),
            .right_score (r_score),
            .key_out     (key_vec[gi]),
            .score_out   (score_vec[gi]),
            .eq_out      (eq_vec[gi]),
            .g_out       (g_vec[gi])
         );
      end
   endgenerate

   // insertion slot is the first slot whose key is larger, or the first empty one
   assign ins_vec = g_vec & ~{g_vec[DEPTH-2:0], 1'b0};
   assign sel_vec = hit ? eq_vec : ins_vec;

   skt_pick #(.DEPTH(DEPTH)) u_pick (
      .sel    (sel_vec),
      .scores (score_vec),
      .index  (pick_idx),
      .score  (pick_score)
   );

   // ---- resolve the held request ----
   assign hit       = |eq_vec;
   assign key_bad   = key_ff[KEY_IN_W-1] || (key_ff == '0);
   assign score_bad = score_ff[SCORE_IN_W-1] || (score_ff[SCORE_W-1:0] > SCORE_MAX);
   assign full      = count_ff == CNT_W'(DEPTH);

   always_comb begin
      case (func_ff)
         FN_UPSERT: begin
            if (key_bad && score_bad)  status_in = ST_BOTH_BAD;
            else if (key_bad)          status_in = ST_BAD_KEY;
            else if (score_bad)        status_in = ST_BAD_SCORE;
            else if (hit)              status_in = ST_UPDATED;
            else if (full)             status_in = ST_FULL;
            else                       status_in = ST_INSERTED;
         end
         FN_DELETE: status_in = hit ? ST_DELETED : ST_NOT_FOUND;
         FN_FIND:   status_in = hit ? ST_FOUND : ST_NOT_FOUND;
         default:   status_in = ST_NOT_FOUND;
      endcase
   end

   assign report    = (status_in == ST_UPDATED) || (status_in == ST_INSERTED) ||
                      (status_in == ST_DELETED) || (status_in == ST_FOUND);
   assign rscore_in = !report ? '0 :
                      (func_ff == FN_UPSERT) ? score_ff[SCORE_W-1:0] : pick_score;

   always_comb begin
      if (!report)                      grade_in = GR_FAIL;
      else if (rscore_in >= excel_thr_ff) grade_in = GR_EXCELLENT;
      else if (rscore_in >= pass_thr_ff)  grade_in = GR_PASS;
      else                              grade_in = GR_FAIL;
   end

   always_comb begin
      count_in = count_ff;
      if (op.insert)      count_in = count_ff + CNT_W'(1);
      else if (op.delete) count_in = count_ff - CNT_W'(1);
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pass_thr_ff  <= PASS_THRESHOLD_RST;
         excel_thr_ff <= EXCEL_THRESHOLD_RST;
      end else begin
         if (accept)    busy_ff <= 1'b1;
         else if (fire) busy_ff <= 1'b0;
         count_ff <= count_in;
         if (fire)           rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_PASS_THRESHOLD:      pass_thr_ff  <= csr_data;
               CSR_EXCELLENT_THRESHOLD: excel_thr_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= req_entry_key;
         score_ff <= req_entry_score;
      end
      if (fire) begin
         status_ff  <= status_in;
         pos_ff     <= report ? POS_W'(pick_idx) : '0;
         rkey_ff    <= report ? key_ff[KEY_W-1:0] : '0;
         rscore_ff  <= rscore_in;
         grade_ff   <= grade_in;
         cnt_out_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_position     = pos_ff;
   assign rsp_result_key   = rkey_ff;
   assign rsp_result_score = rscore_ff;
   assign rsp_grade        = grade_ff;
   assign rsp_entry_count  = cnt_out_ff;

endmodule

// File: hdl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
module skt_checker import skt_pkg::*; #(
   parameter int DEPTH = SKT_DEPTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [STATUS_W-1:0]          rsp_status,
   input logic [POS_W-1:0]             rsp_position,
   input logic [KEY_W-1:0]             rsp_result_key,
   input logic [SCORE_W-1:0]           rsp_result_score,
   input logic [GRADE_W-1:0]           rsp_grade,
   input logic [COUNT_W-1:0]           rsp_entry_count
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_entry_count))
      else $error("stalled result word changed");

   // one item in work: the cycle after an accept must stall
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_W'(DEPTH))
      else $error("entry count above depth");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL ||
                    rsp_status == ST_BAD_KEY || rsp_status == ST_BAD_SCORE ||
                    rsp_status == ST_BOTH_BAD)
      |-> rsp_position == '0 && rsp_result_key == '0 &&
          rsp_result_score == '0 && rsp_grade == GR_FAIL)
      else $error("miss or error result carries entry fields");

   a_insert_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |->
         rsp_result_key != '0 && rsp_entry_count != '0)
      else $error("insert reported a zero key or an empty table");

endmodule

bind sorted_key_table_unit skt_checker #(.DEPTH(DEPTH)) u_skt_checker (.*);

// File: bench/sorted_key_table_unit_tb.sv
// Self-checking bench for the sorted key table: random traffic checked against a predictor.
module sorted_key_table_unit_tb;
   import skt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TBL_DEPTH = SKT_DEPTH;
   localparam int RUN_LIMIT = 400000;
   localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]            func;
      logic signed [KEY_IN_W-1:0]   key;
      logic signed [SCORE_IN_W-1:0] score;
   } req_word_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [KEY_W-1:0]    key;
      logic [SCORE_W-1:0]  score;
      logic [GRADE_W-1:0]  grade;
      logic [COUNT_W-1:0]  count;
   } table_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [FUNC_W-1:0]            req_func = '0;
   logic signed [KEY_IN_W-1:0]   req_entry_key = '0;
   logic signed [SCORE_IN_W-1:0] req_entry_score = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [STATUS_W-1:0]          rsp_status;
   logic [POS_W-1:0]             rsp_position;
   logic [KEY_W-1:0]             rsp_result_key;
   logic [SCORE_W-1:0]           rsp_result_score;
   logic [GRADE_W-1:0]           rsp_grade;
   logic [COUNT_W-1:0]           rsp_entry_count;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [SCORE_W-1:0]           csr_data = '0;

   // predictor state
   logic [KEY_W-1:0]   tbl_key [TBL_DEPTH];
   logic [SCORE_W-1:0] tbl_score [TBL_DEPTH];
   int                 tbl_used = 0;
   logic [SCORE_W-1:0] pass_lvl = PASS_THRESHOLD_RST;
   logic [SCORE_W-1:0] excel_lvl = EXCEL_THRESHOLD_RST;

   req_word_type  req_backlog [$];
   table_rsp_type awaited_rsps [$];
   req_word_type  next_req;
   req_word_type  seen_req;
   table_rsp_type want_rsp;
   logic signed [KEY_IN_W-1:0] key_pool [256];

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   cycle_cnt = 0;
   int   mismatch_cnt = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   int   hold_wait = 200;
   int   stall_epoch = 0;
   int   stall_pct = 0;

   sorted_key_table_unit #(.DEPTH(TBL_DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_entry_key    (req_entry_key),
      .req_entry_score  (req_entry_score),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_result_key   (rsp_result_key),
      .rsp_result_score (rsp_result_score),
      .rsp_grade        (rsp_grade),
      .rsp_entry_count  (rsp_entry_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   // Apply one request to the predicted table and return the word it should produce.
   function automatic table_rsp_type apply_table_op(req_word_type w);
      table_rsp_type r;
      logic [KEY_W-1:0] k;
      int sc, idx, i;
      logic key_ok, score_ok, hit;
      k = w.key[KEY_W-1:0];
      sc = int'(w.score);
      key_ok = (w.key > 0);
      score_ok = (sc >= 0) && (sc <= int'(SCORE_MAX));
      idx = -1;
      hit = 1'b0;
      r.status = ST_NOT_FOUND;
      r.position = '0;
      r.key = '0;
      r.score = '0;
      r.grade = GR_FAIL;
      // stored keys are all positive, so a bad key can never match
      if (key_ok) begin
         for (i = 0; i < tbl_used; i++)
            if (tbl_key[i] == k) idx = i;
      end
      case (w.func)
         FN_UPSERT: begin
            if (!key_ok && !score_ok) r.status = ST_BOTH_BAD;
            else if (!key_ok) r.status = ST_BAD_KEY;
            else if (!score_ok) r.status = ST_BAD_SCORE;
            else if (idx >= 0) begin
               tbl_score[idx] = sc[SCORE_W-1:0];
               r.status = ST_UPDATED;
               hit = 1'b1;
            end else if (tbl_used >= TBL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               i = tbl_used;
               while (i > 0 && tbl_key[i-1] > k) begin
                  tbl_key[i] = tbl_key[i-1];
                  tbl_score[i] = tbl_score[i-1];
                  i--;
               end
               tbl_key[i] = k;
               tbl_score[i] = sc[SCORE_W-1:0];
               tbl_used++;
               idx = i;
               r.status = ST_INSERTED;
               hit = 1'b1;
            end
            if (hit) begin
               r.key = k;
               r.score = sc[SCORE_W-1:0];
            end
         end
         FN_DELETE, FN_FIND: begin
            if (idx >= 0) begin
               hit = 1'b1;
               r.key = tbl_key[idx];
               r.score = tbl_score[idx];
               if (w.func == FN_DELETE) begin
                  // close the gap
                  for (i = idx; i + 1 < tbl_used; i++) begin
                     tbl_key[i] = tbl_key[i+1];
                     tbl_score[i] = tbl_score[i+1];
                  end
                  tbl_used--;
                  r.status = ST_DELETED;
               end else begin
                  r.status = ST_FOUND;
               end
            end
         end
         default: ;
      endcase
      if (hit) begin
         r.position = idx[POS_W-1:0];
         if (r.score >= excel_lvl) r.grade = GR_EXCELLENT;
         else if (r.score >= pass_lvl) r.grade = GR_PASS;
      end
      r.count = tbl_used[COUNT_W-1:0];
      return r;
   endfunction

   function automatic req_word_type random_table_op(int pool_n, int upsert_w);
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.key = key_pool[$urandom_range(0, pool_n - 1)];
      w.score = SCORE_IN_W'($urandom_range(0, SCORE_MAX));
      if (pick < upsert_w) begin
         w.func = FN_UPSERT;
         if ($urandom_range(0, 9) == 0) w.score = SCORE_IN_W'($urandom_range(0, 2047));
      end else if (pick < upsert_w + (88 - upsert_w) / 2) begin
         w.func = FN_DELETE;
      end else if (pick < 88) begin
         w.func = FN_FIND;
      end else begin
         // noise: any code, any key, any score
         w.func = FUNC_W'($urandom_range(0, 3));
         w.key = $urandom;
         w.score = SCORE_IN_W'($urandom_range(0, 2047));
      end
      return w;
   endfunction

   task automatic push_op(input logic [FUNC_W-1:0] f, input logic signed [KEY_IN_W-1:0] k,
                          input logic signed [SCORE_IN_W-1:0] s);
      req_word_type w;
      w.func = f;
      w.key = k;
      w.score = s;
      req_backlog.push_back(w);
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [SCORE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int n, input int pool_n, input int upsert_w);
      int i;
      for (i = 0; i < pool_n; i++) begin
         if ($urandom_range(0, 2) == 0) key_pool[i] = $urandom_range(1, 400);
         else key_pool[i] = $urandom_range(1, 32'h7FFF_FFFF);
      end
      key_pool[0] = 32'sh7FFF_FFFF;
      for (i = 0; i < n; i++) req_backlog.push_back(random_table_op(pool_n, upsert_w));
      wait_drained();
   endtask

   // driver: offer request words in bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0 || req_backlog.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_req = req_backlog.pop_front();
            req_func <= next_req.func;
            req_entry_key <= next_req.key;
            req_entry_score <= next_req.score;
            req_valid <= 1'b1;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1, 2: gap_left = $urandom_range(1, 4);
                  default: gap_left = $urandom_range(5, 30);
               endcase
            end
         end
      end
   end

   // long receiver hold-off, so the table backs up into the request side
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_wait != 0) begin
         hold_wait <= hold_wait - 1;
      end else begin
         hold_left <= $urandom_range(40, 90);
         hold_wait <= $urandom_range(300, 900);
      end
   end

   // receiver: stall density changes from one stretch to the next
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_epoch == 0) begin
            stall_epoch = $urandom_range(16, 96);
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 30;
               3: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         stall_epoch--;
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted result words
   always @(posedge clock) begin
      if (cycle_cnt >= RUN_LIMIT) begin
         $display("sorted_key_table_unit verification failed");
         $finish;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         req_taken <= !reset && req_valid && !req_stall;
         csr_taken <= !reset && csr_valid && csr_ready;
         if (!reset) begin
            if (csr_valid && csr_ready) begin
               case (csr_index)
                  CSR_PASS_THRESHOLD: pass_lvl = csr_data;
                  CSR_EXCELLENT_THRESHOLD: excel_lvl = csr_data;
                  default: ;
               endcase
            end
            if (req_valid && !req_stall) begin
               seen_req.func = req_func;
               seen_req.key = req_entry_key;
               seen_req.score = req_entry_score;
               awaited_rsps.push_back(apply_table_op(seen_req));
            end
            if (rsp_valid && !rsp_stall) begin
               if (awaited_rsps.size() == 0) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("%0t: unexpected result word: status %0d key %0d", $time,
                              rsp_status, rsp_result_key);
               end else begin
                  want_rsp = awaited_rsps.pop_front();
                  if (want_rsp.status !== rsp_status || want_rsp.position !== rsp_position ||
                      want_rsp.key !== rsp_result_key || want_rsp.score !== rsp_result_score ||
                      want_rsp.grade !== rsp_grade || want_rsp.count !== rsp_entry_count) begin
                     mismatch_cnt++;
                     if (mismatch_cnt <= 10) begin
                        $display("%0t: mismatch exp st=%0d pos=%0d key=%0d score=%0d %s%0d %s%0d",
                                 $time, want_rsp.status, want_rsp.position, want_rsp.key,
                                 want_rsp.score, "grade=", want_rsp.grade,
                                 "count=", want_rsp.count);
                        $display("%0t:          got st=%0d pos=%0d key=%0d score=%0d %s%0d %s%0d",
                                 $time, rsp_status, rsp_position, rsp_result_key,
                                 rsp_result_score, "grade=", rsp_grade,
                                 "count=", rsp_entry_count);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      int i, j;
      logic signed [KEY_IN_W-1:0] fill_keys [140];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, key and score limits, every status but full, grade edges
      push_op(FN_FIND, 32'sd5, 11'sd0);
      push_op(FN_DELETE, 32'sd5, 11'sd0);
      push_op(FN_UPSERT, 32'sd1, 11'sd0);
      push_op(FN_UPSERT, 32'sh7FFF_FFFF, 11'sd1000);
      push_op(FN_UPSERT, 32'sd1000, 11'sd599);
      push_op(FN_UPSERT, 32'sd500, 11'sd600);
      push_op(FN_UPSERT, 32'sd0, 11'sd500);
      push_op(FN_UPSERT, -32'sd1, 11'sd1000);
      push_op(FN_UPSERT, 32'sh8000_0000, -11'sd1);
      push_op(FN_UPSERT, 32'sd77, 11'sd1001);
      push_op(FN_UPSERT, 32'sd77, 11'h400);
      push_op(FN_UPSERT, 32'sd77, 11'sd1023);
      push_op(FN_UPSERT, -32'sd7, 11'sd1023);
      push_op(FN_UPSERT, 32'sd1, 11'sd850);
      push_op(FN_UPSERT, 32'sd1000, 11'sd849);
      push_op(FN_FIND, 32'sh7FFF_FFFF, 11'sd0);
      push_op(FN_FIND, -32'sd5, 11'sd0);
      push_op(FN_FIND, 32'sd0, 11'sd0);
      push_op(FN_DELETE, -32'sd1000, 11'sd0);
      push_op(FN_SPARE, 32'sd1, 11'sd10);
      push_op(FN_DELETE, 32'sd1, 11'sd0);
      push_op(FN_DELETE, 32'sd1, 11'sd0);
      push_op(FN_FIND, 32'sd500, 11'sd0);
      push_op(FN_DELETE, 32'sh7FFF_FFFF, 11'sd0);
      push_op(FN_FIND, 32'sd1000, 11'sd0);
      push_op(FN_DELETE, 32'sh8000_0000, 11'sd0);
      wait_drained();

      run_random_phase(300, 40, 40);

      write_threshold(CSR_PASS_THRESHOLD, 10'd0);
      write_threshold(CSR_EXCELLENT_THRESHOLD, 10'd1000);
      run_random_phase(300, 12, 35);

      // excellent below pass
      write_threshold(CSR_PASS_THRESHOLD, 10'd701);
      write_threshold(CSR_EXCELLENT_THRESHOLD, 10'd301);
      run_random_phase(250, 60, 45);

      // fill past capacity, hit the full table, then empty it in random order
      write_threshold(CSR_PASS_THRESHOLD, 10'd1000);
      write_threshold(CSR_EXCELLENT_THRESHOLD, 10'd1000);
      for (i = 0; i < 140; i++) begin
         fill_keys[i] = $urandom_range(1, 32'h7FFF_FFFF);
         push_op(FN_UPSERT, fill_keys[i], SCORE_IN_W'($urandom_range(0, SCORE_MAX)));
      end
      for (i = 0; i < 40; i++)
         push_op(($urandom_range(0, 2) == 0) ? FN_FIND : FN_UPSERT,
                 fill_keys[$urandom_range(0, 139)],
                 SCORE_IN_W'($urandom_range(0, SCORE_MAX)));
      for (i = 139; i >= 0; i--) begin
         j = $urandom_range(0, i);
         push_op(FN_DELETE, fill_keys[j], SCORE_IN_W'($urandom_range(0, 2047)));
         fill_keys[j] = fill_keys[i];
      end
      push_op(FN_FIND, 32'sd1, 11'sd0);
      wait_drained();

      write_threshold(CSR_PASS_THRESHOLD, 10'd0);
      write_threshold(CSR_EXCELLENT_THRESHOLD, 10'd0);
      run_random_phase(300, 200, 50);

      write_threshold(CSR_PASS_THRESHOLD, PASS_THRESHOLD_RST);
      write_threshold(CSR_EXCELLENT_THRESHOLD, EXCEL_THRESHOLD_RST);
      run_random_phase(350, 150, 55);

      repeat (16) @(posedge clock);
      if (mismatch_cnt == 0 && awaited_rsps.size() == 0) begin
         $display("sorted_key_table_unit verification clean");
      end else begin
         $display("sorted_key_table_unit verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/skt_pick.sv
hdl/sorted_key_table_unit.sv
hdl/skt_checker.sv
bench/sorted_key_table_unit_tb.sv
